// ----- src/wsmo_pkg.sv -----
// wsmo_pkg: request/response payload types, store entry type, sequencer
// states and fixed constants for the offset anchor block. No dependencies.
`timescale 1ns / 1ps

package wsmo_pkg;

   localparam int WINDOW_W = 63;
   localparam int COUNT_W  = 4;
   localparam int ANCHOR_MIN_COUNT = 2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 63'd60000000000;
   localparam logic signed [63:0] OFFSET_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] CUTOFF_FLOOR = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0]        boot_id;
      logic signed [63:0] offset;
      logic signed [63:0] sample_time;
   } req_type;

   typedef struct packed {
      logic signed [63:0]  anchor;
      logic [COUNT_W-1:0]  stored_count;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] offset;
      logic signed [63:0] sample_time;
   } entry_type;

   typedef struct packed {
      logic lt_b;
      logic lt_c;
   } cmp_result_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CUTOFF = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_SHIFT  = 7'b0001000,
      ST_APPEND = 7'b0010000,
      ST_SEARCH = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

endpackage

// ----- src/wsmo_ram.sv -----
// wsmo_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsmo_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wsmo_cmp.sv -----
// wsmo_cmp: shared signed compare unit, one operand against two references.
// Depends on wsmo_pkg for the result struct.
`timescale 1ns / 1ps

module wsmo_cmp
   import wsmo_pkg::*;
(
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  logic signed [63:0] op_c,
   output cmp_result_type     result
);

   assign result.lt_b = op_a < op_b;
   assign result.lt_c = op_a < op_c;

endmodule

// ----- src/windowed_second_min_offset_anchor_top.sv -----
// windowed_second_min_offset_anchor_top: sequencer, sample store and result
// register. Depends on wsmo_pkg, wsmo_ram and wsmo_cmp.
//
//   channel | ports                            | payload
//   request | req_valid  req_ready  req_data   | req_type
//   result  | rsp_valid  rsp_ready  rsp_data   | rsp_type
//   config  | csr_valid  csr_ready  csr_data   | window_ns, 63 bits
//
// A request passes through the cutoff, scan, shift, append, search and result
// states; shift runs only when the store is still full after age-out. The walks
// over the store RAM (scan, shift, search) read one entry a cycle through its read
// port.
// Reset clears the boot id, the fill count and the result flag and loads the
// window with its 60 s default.
// req_ready is high only in idle; a result not yet taken holds the sequencer
// before it loads the next one, and no requests are accepted meanwhile.
`timescale 1ns / 1ps

module windowed_second_min_offset_anchor_top
   import wsmo_pkg::*;
#(
   parameter int MAX_SAMPLES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WINDOW_W-1:0] csr_data
);

   localparam int IW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SAMPLES);
   localparam logic [CW-1:0] COUNT_MIN  = CW'(ANCHOR_MIN_COUNT);

   state_type          state_ff, state_in;
   logic [63:0]        boot_ff, boot_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic signed [63:0] offset_ff, offset_in;
   logic signed [63:0] time_ff, time_in;
   logic signed [63:0] cutoff_ff, cutoff_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               data_vld_ff, data_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic signed [63:0] low_ff, low_in;
   logic signed [63:0] next_ff, next_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   entry_type          wr_data;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   entry_type          rd_data;
   logic [$bits(entry_type)-1:0] rd_bits;

   logic signed [63:0] cmp_a, cmp_b;
   cmp_result_type     cmp_res;
   logic [64:0]        diff;

   wsmo_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_data = entry_type'(rd_bits);

   assign cmp_a = (state_ff == ST_SCAN) ? rd_data.sample_time : rd_data.offset;
   assign cmp_b = (state_ff == ST_SCAN) ? cutoff_ff : low_ff;

   wsmo_cmp u_cmp (
      .op_a  (cmp_a),
      .op_b  (cmp_b),
      .op_c  (next_ff),
      .result(cmp_res)
   );

   assign diff = {time_ff[63], time_ff} - {2'b00, window_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      count_in     = count_ff;
      window_in    = window_ff;
      offset_in    = offset_ff;
      time_in      = time_ff;
      cutoff_in    = cutoff_ff;
      issue_in     = issue_ff;
      data_vld_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      kept_in      = kept_ff;
      low_in       = low_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = kept_ff[IW-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IW-1:0];

      if (csr_valid && csr_ready) begin
         window_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               offset_in = req_data.offset;
               time_in   = req_data.sample_time;
               if (req_data.boot_id != boot_ff) begin
                  boot_in  = req_data.boot_id;
                  count_in = '0;
               end
               state_in = ST_CUTOFF;
            end
         end
         ST_CUTOFF: begin
            cutoff_in = (diff[64] != diff[63]) ? CUTOFF_FLOOR : diff[63:0];
            issue_in  = '0;
            kept_in   = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_idx_in   = issue_ff[IW-1:0];
               issue_in    = issue_ff + CW'(1);
               data_vld_in = 1'b1;
            end
            if (data_vld_ff && !cmp_res.lt_b) begin
               wr_en   = 1'b1;
               kept_in = kept_ff + CW'(1);
            end
            if (!(issue_ff < count_ff) && !data_vld_ff) begin
               count_in = kept_ff;
               if (kept_ff == COUNT_FULL) begin
                  issue_in = CW'(1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_APPEND;
               end
            end
         end
         ST_SHIFT: begin
            if (issue_ff < COUNT_FULL) begin
               rd_en       = 1'b1;
               rd_idx_in   = issue_ff[IW-1:0];
               issue_in    = issue_ff + CW'(1);
               data_vld_in = 1'b1;
            end
            if (data_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IW'(1);
            end
            if (!(issue_ff < COUNT_FULL) && !data_vld_ff) begin
               count_in = COUNT_FULL - CW'(1);
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            wr_en               = 1'b1;
            wr_addr             = count_ff[IW-1:0];
            wr_data.offset      = offset_ff;
            wr_data.sample_time = time_ff;
            count_in            = count_ff + CW'(1);
            issue_in            = '0;
            low_in              = OFFSET_MAX;
            next_in             = OFFSET_MAX;
            state_in            = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CW'(1);
               data_vld_in = 1'b1;
            end
            if (data_vld_ff) begin
               if (cmp_res.lt_b) begin
                  next_in = low_ff;
                  low_in  = rd_data.offset;
               end else if (cmp_res.lt_c) begin
                  next_in = rd_data.offset;
               end
            end
            if (!(issue_ff < count_ff) && !data_vld_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.anchor       = (count_ff < COUNT_MIN) ? low_ff : next_ff;
               rsp_in.stored_count = COUNT_W'(count_ff);
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         boot_ff      <= '0;
         count_ff     <= '0;
         window_ff    <= WINDOW_RESET;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      time_ff   <= time_in;
      cutoff_ff <= cutoff_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
      kept_ff   <= kept_in;
      low_ff    <= low_in;
      next_ff   <= next_in;
      rsp_ff    <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("fill count above store depth");

   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (kept_ff <= issue_ff))
      else $error("compaction write pointer ahead of read pointer");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < (IW + 1)'(MAX_SAMPLES)))
      else $error("store write beyond depth");

   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && rsp_ff.stored_count != '0))
      else $error("result loaded with empty store");
`endif

endmodule

// ----- tb/tb_windowed_second_min_offset_anchor_top.sv -----
// tb_windowed_second_min_offset_anchor_top: self-checking bench for the offset anchor block.
// Drives requests, window writes and result stalls; a store model predicts all but typed rows.
// Depends on wsmo_pkg and windowed_second_min_offset_anchor_top.
`timescale 1ns / 1ps

module tb_windowed_second_min_offset_anchor_top;
   import wsmo_pkg::*;

   localparam int STORE_DEPTH   = 8;
   localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 8 + STORE_DEPTH + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_ROWS      = 20;

   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] BOOT_A  = 64'h5555_5555_5555_5555;
   localparam logic [63:0] BOOT_B  = 64'hAAAA_AAAA_AAAA_AAAA;

   typedef struct packed {
      logic        typed;
      logic [63:0] boot_id;
      logic [63:0] offset;
      logic [63:0] sample_time;
      logic [63:0] anchor;
      logic [3:0]  stored_count;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WINDOW_W-1:0] csr_data = '0;

   windowed_second_min_offset_anchor_top #(
      .MAX_SAMPLES(STORE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // store model
   logic [WINDOW_W-1:0] window_now = WINDOW_RESET;
   logic [63:0]         boot_now = '0;
   logic signed [63:0]  held_off [STORE_DEPTH];
   logic signed [63:0]  held_at [STORE_DEPTH];
   int                  held_n = 0;

   rsp_type due_anchors[$];
   int      requests_sent = 0;
   int      anchors_seen = 0;
   int      bad_anchors = 0;
   int      windows_used = 1;

   bit      idle_on = 1'b1;
   logic    rsp_hold = 1'b0;
   int      rsp_stall = 0;
   event    hold_start;

   logic [63:0]        gen_boot = '0;
   logic signed [63:0] gen_off = '0;
   logic signed [63:0] gen_time = '0;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{1'b1, 64'd0, 64'd10, 64'd0, 64'd10, 4'd1},
      '{1'b1, 64'd0, 64'd10, 64'd5, 64'd10, 4'd2},
      '{1'b0, 64'd0, -64'sd3, 64'd6, 64'd0, 4'd0},
      '{1'b0, 64'd0, S64_MAX, 64'd60000000005, 64'd0, 4'd0},
      '{1'b1, ~64'd0, S64_MIN, S64_MIN, S64_MIN, 4'd1},
      '{1'b1, ~64'd0, S64_MAX, S64_MIN, S64_MAX, 4'd2},
      '{1'b1, ~64'd0, 64'd0, S64_MAX, 64'd0, 4'd1},
      '{1'b0, BOOT_A, 64'd7, 64'd100, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd3, 64'd101, 64'd0, 4'd0},
      '{1'b0, BOOT_A, -64'sd1, 64'd102, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd9, 64'd103, 64'd0, 4'd0},
      '{1'b0, BOOT_A, -64'sd1, 64'd104, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd4, 64'd105, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd2, 64'd106, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd8, 64'd107, 64'd0, 4'd0},
      '{1'b0, BOOT_A, 64'd5, 64'd108, 64'd0, 4'd0},
      '{1'b0, BOOT_A, -64'sd100, 64'd109, 64'd0, 4'd0},
      '{1'b1, BOOT_B, 64'd1, -64'sd1, 64'd1, 4'd1},
      '{1'b0, BOOT_B, 64'd2, -64'sd60000000001, 64'd0, 4'd0},
      '{1'b0, BOOT_B, 64'd2, 64'd59999999999, 64'd0, 4'd0}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type advance_store(input req_type r);
      logic signed [63:0] span;
      logic signed [63:0] cut;
      logic signed [63:0] low;
      logic signed [63:0] nxt;
      int                 kept;
      rsp_type            res;
      if (r.boot_id != boot_now) begin
         boot_now = r.boot_id;
         held_n = 0;
      end
      span = $signed({1'b0, window_now});
      if (r.sample_time < CUTOFF_FLOOR + span) begin
         cut = CUTOFF_FLOOR;
      end else begin
         cut = r.sample_time - span;
      end
      kept = 0;
      for (int i = 0; i < held_n; i++) begin
         if (held_at[i] >= cut) begin
            held_off[kept] = held_off[i];
            held_at[kept] = held_at[i];
            kept++;
         end
      end
      held_n = kept;
      if (held_n >= STORE_DEPTH) begin
         for (int i = 1; i < STORE_DEPTH; i++) begin
            held_off[i-1] = held_off[i];
            held_at[i-1] = held_at[i];
         end
         held_n = STORE_DEPTH - 1;
      end
      held_off[held_n] = r.offset;
      held_at[held_n] = r.sample_time;
      held_n++;
      low = OFFSET_MAX;
      nxt = OFFSET_MAX;
      for (int i = 0; i < held_n; i++) begin
         if (held_off[i] < low) begin
            nxt = low;
            low = held_off[i];
         end else if (held_off[i] < nxt) begin
            nxt = held_off[i];
         end
      end
      res.anchor = (held_n < ANCHOR_MIN_COUNT) ? low : nxt;
      res.stored_count = COUNT_W'(held_n);
      return res;
   endfunction

   function automatic req_type make_sample();
      req_type     r;
      logic [63:0] step;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         gen_boot = {$urandom, $urandom};
      end else if (pick < 5) begin
         gen_boot = '0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         gen_off = 64'($urandom_range(0, 200)) - 64'd100;
      end else if (pick >= 75) begin
         gen_off = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
         0: begin
            step = '0;
         end
         1, 2, 3, 4, 5: begin
            step = 64'($urandom_range(1, 40));
         end
         6, 7: begin
            step = 64'(window_now) >> $urandom_range(1, 4);
         end
         8: begin
            step = 64'(window_now);
         end
         default: begin
            step = '0;
            gen_time = {$urandom, $urandom};
         end
      endcase
      gen_time = gen_time + step;
      r.boot_id = gen_boot;
      r.offset = gen_off;
      r.sample_time = gen_time;
      return r;
   endfunction

   task automatic push_request(input req_type r, input bit use_given, input rsp_type given);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_store(r);
      due_anchors.push_back(use_given ? given : predicted);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_anchors.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] w);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      window_now = w;
      windows_used++;
   endtask

   task automatic run_phase(input int n_items, input int hold_at_item, input int pause_at_item);
      req_type r;
      gen_time = {$urandom, $urandom};
      for (int k = 0; k < n_items; k++) begin
         if (k == hold_at_item) begin
            -> hold_start;
         end
         if (k == pause_at_item) begin
            drain_results();
         end
         r = make_sample();
         push_request(r, 1'b0, '0);
      end
   endtask

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_start);
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         anchors_seen++;
         if (due_anchors.size() == 0) begin
            bad_anchors++;
            if (bad_anchors <= 10) begin
               $display("[%0t] result with none pending: anchor %0d count %0d",
                        $realtime, rsp_data.anchor, rsp_data.stored_count);
            end
         end else begin
            want = due_anchors.pop_front();
            if (rsp_data.anchor !== want.anchor ||
                rsp_data.stored_count !== want.stored_count) begin
               bad_anchors++;
               if (bad_anchors <= 10) begin
                  $display("[%0t] result %0d: expected anchor %0d count %0d,",
                           $realtime, anchors_seen, want.anchor, want.stored_count,
                           " got anchor %0d count %0d",
                           rsp_data.anchor, rsp_data.stored_count);
               end
            end
         end
      end
   end

   initial begin
      req_type r;
      rsp_type given;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_ROWS; k++) begin
         r.boot_id = directed_rows[k].boot_id;
         r.offset = directed_rows[k].offset;
         r.sample_time = directed_rows[k].sample_time;
         given.anchor = directed_rows[k].anchor;
         given.stored_count = directed_rows[k].stored_count;
         push_request(r, directed_rows[k].typed, given);
      end

      write_window('0);
      run_phase(130, -1, -1);
      write_window({WINDOW_W{1'b1}});
      run_phase(130, -1, -1);
      write_window(63'd1000);
      run_phase(150, 40, -1);
      write_window(63'd50);
      run_phase(150, -1, 75);
      write_window(WINDOW_W'({$urandom, $urandom}));
      run_phase(130, -1, -1);
      write_window(WINDOW_RESET);
      idle_on <= 1'b0;
      run_phase(150, -1, -1);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("summary: %0d requests, %0d results checked, %0d window settings, %0d bad",
               requests_sent, anchors_seen, windows_used, bad_anchors);
      $display("summary: boot changes, age-out at the cutoff, full-store drops, stalls covered");
      if (bad_anchors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d results still pending", due_anchors.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
src/wsmo_pkg.sv
src/wsmo_ram.sv
src/wsmo_cmp.sv
src/windowed_second_min_offset_anchor_top.sv
tb/tb_windowed_second_min_offset_anchor_top.sv
